[hw/rtl/greedy_box_suppression_unit_macros.svh]
// assertion macros shared by the greedy box suppression rtl
// sampled on clk_i, disabled while rst_ni is low; no other dependencies
`ifndef GREEDY_BOX_SUPPRESSION_UNIT_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_UNIT_MACROS_SVH

// condition holds on every enabled clock edge
`define GBS_ASSERT_ALW(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GBS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define GBS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gbs_pkg.sv]
// constants, widths and token types of the greedy box suppression unit
// used by gbs_cell and greedy_box_suppression_unit; no dependencies
`default_nettype none

package gbs_pkg;

  localparam int unsigned MAX_KEPT   = 64;
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned NCELL      = MAX_KEPT + 2;  // two tail cells finish the skew
  localparam int unsigned CNT_W      = $clog2(MAX_KEPT + 1);
  localparam int unsigned LEN_W      = COORD_BITS;
  localparam int unsigned END_W      = COORD_BITS + 2;
  localparam int unsigned AREA_W     = 2 * COORD_BITS;
  localparam int unsigned SUM_W      = AREA_W + 1;
  localparam int unsigned PROD_W     = THR_W + SUM_W;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned TOTAL_W    = 7;
  localparam int unsigned IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = ((SLOT_W + TOTAL_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(29491);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0]        width;
    logic [COORD_BITS-1:0]        height;
    logic [AREA_W-1:0]            area;
  } gbs_box_t;

  // overlap lengths of one pair
  typedef struct packed {
    logic             v;
    logic [LEN_W-1:0] iw;
    logic [LEN_W-1:0] ih;
    logic [SUM_W-1:0] sum;
  } gbs_s1_t;

  // intersection and union of one pair
  typedef struct packed {
    logic              v;
    logic [AREA_W-1:0] inter;
    logic [SUM_W-1:0]  uni;
  } gbs_s2_t;

  typedef struct packed {
    gbs_box_t qry;
    gbs_s1_t  s1;
    gbs_s2_t  s2;
    logic     sup;
  } gbs_pay_t;

  typedef struct packed {
    logic     vld;
    gbs_pay_t pay;
  } gbs_tok_t;

  typedef struct packed {
    logic               kept;
    logic [SLOT_W-1:0]  slot;
    logic               full;
    logic [TOTAL_W-1:0] total;
  } gbs_res_t;

endpackage

`default_nettype wire

[hw/rtl/gbs_cell.sv]
// one cell of the suppression chain: holds one kept box and runs a skewed
// three step overlap test on the passing token; depends on gbs_pkg
`default_nettype none

module gbs_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           live_i,
  input  logic                           wr_en_i,
  input  gbs_pkg::gbs_box_t              wr_box_i,
  input  logic [gbs_pkg::THR_W-1:0]      thr_i,
  input  gbs_pkg::gbs_tok_t              tok_i,
  output gbs_pkg::gbs_tok_t              tok_o
);

  gbs_pkg::gbs_box_t box_q;
  logic              vld_q;
  gbs_pkg::gbs_pay_t pay_q;
  gbs_pkg::gbs_pay_t pay_d;

  logic [gbs_pkg::AREA_W-1:0] inter_c;
  logic [gbs_pkg::PROD_W-1:0] lhs_c;
  logic [gbs_pkg::PROD_W-1:0] rhs_c;

  function automatic logic [gbs_pkg::LEN_W-1:0] overlap(
    input logic signed [gbs_pkg::COORD_BITS-1:0] a0,
    input logic        [gbs_pkg::COORD_BITS-1:0] alen,
    input logic signed [gbs_pkg::COORD_BITS-1:0] b0,
    input logic        [gbs_pkg::COORD_BITS-1:0] blen
  );
    logic signed [gbs_pkg::END_W-1:0] ea;
    logic signed [gbs_pkg::END_W-1:0] eb;
    logic signed [gbs_pkg::END_W-1:0] lo;
    logic signed [gbs_pkg::END_W-1:0] hi;
    logic signed [gbs_pkg::END_W-1:0] diff;
    ea   = gbs_pkg::END_W'(a0) + $signed(gbs_pkg::END_W'(alen));
    eb   = gbs_pkg::END_W'(b0) + $signed(gbs_pkg::END_W'(blen));
    lo   = (a0 > b0) ? gbs_pkg::END_W'(a0) : gbs_pkg::END_W'(b0);
    hi   = (ea < eb) ? ea : eb;
    diff = hi - lo;
    return (hi > lo) ? gbs_pkg::LEN_W'(diff) : '0;
  endfunction

  always_comb begin
    pay_d     = tok_i.pay;

    // step one: this cell's box against the query
    pay_d.s1.v   = live_i;
    pay_d.s1.iw  = overlap(tok_i.pay.qry.left, tok_i.pay.qry.width,
                           box_q.left, box_q.width);
    pay_d.s1.ih  = overlap(tok_i.pay.qry.top, tok_i.pay.qry.height,
                           box_q.top, box_q.height);
    pay_d.s1.sum = gbs_pkg::SUM_W'(tok_i.pay.qry.area) + gbs_pkg::SUM_W'(box_q.area);

    // step two: previous cell's pair
    inter_c        = gbs_pkg::AREA_W'(tok_i.pay.s1.iw) * gbs_pkg::AREA_W'(tok_i.pay.s1.ih);
    pay_d.s2.v     = tok_i.pay.s1.v;
    pay_d.s2.inter = inter_c;
    pay_d.s2.uni   = tok_i.pay.s1.sum - gbs_pkg::SUM_W'(inter_c);

    // step three: pair from two cells back, inter * 2^16 > thr * union
    lhs_c     = gbs_pkg::PROD_W'({tok_i.pay.s2.inter, {gbs_pkg::THR_W{1'b0}}});
    rhs_c     = gbs_pkg::PROD_W'(thr_i) * gbs_pkg::PROD_W'(tok_i.pay.s2.uni);
    pay_d.sup = tok_i.pay.sup | (tok_i.pay.s2.v & (lhs_c > rhs_c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
    if (wr_en_i) begin
      box_q <= wr_box_i;
    end
  end

  always_comb begin
    tok_o.vld = vld_q;
    tok_o.pay = pay_q;
  end

endmodule

`default_nettype wire

[hw/rtl/greedy_box_suppression_unit.sv]
// top level of the greedy box suppression unit: stream ports, control and
// the chain of gbs_cell instances; depends on gbs_pkg, gbs_cell and the macro header
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata: box, tuser: frame_start
//   m_axis    out        m_axis_tvalid/tready       tdata: slot, total, tuser: flags
//   cfg       in         cfg_valid_i/cfg_ready_o    cfg_data_i: iou_threshold
//
// an accepted transaction is held in the head register, then its query token walks one
// cell per cycle through MAX_KEPT + 2 cells; no new transaction is accepted meanwhile.
// the edge that registers the result in the output register also raises ready again,
// and the result shows on m_axis from that register.
// reset empties the kept list and loads the default threshold; no clearing pass.
// a stalled result sits in the output register while the next item is accepted and walks the
// chain; a result behind it parks in a hold register and keeps ready low until it moves up.
`default_nettype none

`include "greedy_box_suppression_unit_macros.svh"

module greedy_box_suppression_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gbs_pkg::THR_W-1:0]         cfg_data_i,      // iou_threshold
  // input boxes
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gbs_pkg::IN_DATA_W-1:0]     s_axis_tdata,    // box_left, box_top,
                                                             // box_width, box_height
  input  logic [gbs_pkg::IN_USER_W-1:0]     s_axis_tuser,    // frame_start
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gbs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,    // kept_slot, kept_total
  output logic [gbs_pkg::OUT_USER_W-1:0]    m_axis_tuser     // kept, list_full
);

  localparam int unsigned CB = gbs_pkg::COORD_BITS;

  // threshold register
  logic [gbs_pkg::THR_W-1:0] thr_q;

  // control state
  logic                     busy_q, busy_d;
  logic [gbs_pkg::CNT_W-1:0] count_q, count_d;
  logic                     inj_vld_q;
  gbs_pkg::gbs_pay_t        inj_pay_q, inj_pay_d;
  logic                     m_vld_q, m_vld_d;
  gbs_pkg::gbs_res_t        m_res_q, m_res_d;
  logic                     hold_vld_q, hold_vld_d;
  gbs_pkg::gbs_res_t        hold_res_q, hold_res_d;

  logic s_acc;
  logic m_take;
  logic ex;
  logic keep;
  logic has_room;
  logic store;
  gbs_pkg::gbs_res_t res_c;

  // chain wiring
  gbs_pkg::gbs_tok_t          tok [gbs_pkg::NCELL+1];
  logic [gbs_pkg::NCELL:0]    tok_vld;
  logic [gbs_pkg::NCELL-1:0]  live;
  logic [gbs_pkg::NCELL-1:0]  wr_en;
  gbs_pkg::gbs_box_t          wr_box;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_take        = m_vld_q && m_axis_tready;

  // query token injected into the head of the chain
  always_comb begin
    inj_pay_d             = '0;
    inj_pay_d.qry.left    = s_axis_tdata[0*CB +: CB];
    inj_pay_d.qry.top     = s_axis_tdata[1*CB +: CB];
    inj_pay_d.qry.width   = s_axis_tdata[2*CB +: CB];
    inj_pay_d.qry.height  = s_axis_tdata[3*CB +: CB];
    inj_pay_d.qry.area    = gbs_pkg::AREA_W'(s_axis_tdata[2*CB +: CB]) *
                            gbs_pkg::AREA_W'(s_axis_tdata[3*CB +: CB]);
  end

  assign tok[0].vld = inj_vld_q;
  assign tok[0].pay = inj_pay_q;

  // cells below the fill count take part; a kept box goes to the cell at the count
  for (genvar j = 0; j < gbs_pkg::NCELL; j++) begin : g_chain
    if (j < gbs_pkg::MAX_KEPT) begin : g_store
      assign live[j]  = count_q > gbs_pkg::CNT_W'(j);
      assign wr_en[j] = ex && store && (count_q == gbs_pkg::CNT_W'(j));
    end else begin : g_tail
      assign live[j]  = 1'b0;
      assign wr_en[j] = 1'b0;
    end

    gbs_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .live_i   (live[j]),
      .wr_en_i  (wr_en[j]),
      .wr_box_i (wr_box),
      .thr_i    (thr_q),
      .tok_i    (tok[j]),
      .tok_o    (tok[j+1])
    );
  end

  for (genvar k = 0; k <= gbs_pkg::NCELL; k++) begin : g_vld
    assign tok_vld[k] = tok[k].vld;
  end

  // token leaving the tail carries the final suppress decision
  assign ex       = tok[gbs_pkg::NCELL].vld;
  assign keep     = !tok[gbs_pkg::NCELL].pay.sup;
  assign has_room = count_q < gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT);
  assign store    = keep && has_room;
  assign wr_box   = tok[gbs_pkg::NCELL].pay.qry;

  always_comb begin
    res_c.kept  = keep;
    res_c.full  = keep && !has_room;
    res_c.slot  = store ? gbs_pkg::SLOT_W'(count_q) : '0;
    res_c.total = gbs_pkg::TOTAL_W'(count_q + gbs_pkg::CNT_W'(store));
  end

  always_comb begin
    busy_d     = busy_q;
    count_d    = count_q;
    m_vld_d    = m_vld_q;
    m_res_d    = m_res_q;
    hold_vld_d = hold_vld_q;
    hold_res_d = hold_res_q;

    if (s_acc) begin
      busy_d = 1'b1;
      if (s_axis_tuser[0]) begin
        count_d = '0;  // new frame empties the kept list
      end
    end

    if (m_take) begin
      m_vld_d = 1'b0;
    end

    if (ex) begin
      count_d = count_q + gbs_pkg::CNT_W'(store);
      if (!m_vld_q || m_take) begin
        m_vld_d = 1'b1;
        m_res_d = res_c;
        busy_d  = 1'b0;
      end else begin
        hold_vld_d = 1'b1;
        hold_res_d = res_c;
      end
    end else if (hold_vld_q && m_take) begin
      // parked result moves up once the output register frees
      m_vld_d    = 1'b1;
      m_res_d    = hold_res_q;
      hold_vld_d = 1'b0;
      busy_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= gbs_pkg::THR_RESET;
      busy_q     <= 1'b0;
      count_q    <= '0;
      inj_vld_q  <= 1'b0;
      m_vld_q    <= 1'b0;
      hold_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      busy_q     <= busy_d;
      count_q    <= count_d;
      inj_vld_q  <= s_acc;
      m_vld_q    <= m_vld_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      inj_pay_q <= inj_pay_d;
    end
    m_res_q    <= m_res_d;
    hold_res_q <= hold_res_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = gbs_pkg::OUT_DATA_W'({m_res_q.total, m_res_q.slot});
  assign m_axis_tuser  = {m_res_q.full, m_res_q.kept};

  // at most one query token in flight anywhere in the chain
  `GBS_ASSERT_ALW(a_one_token, $onehot0(tok_vld), "more than one token in the chain")
  // an accepted transaction enters the chain on the next cycle
  `GBS_ASSERT_NXT(a_inject, s_acc, inj_vld_q, "accepted box not injected")
  // a token only leaves the chain while its item is pending and nothing is parked
  `GBS_ASSERT_IMP(a_exit_busy, ex, busy_q && !hold_vld_q, "token exit while not busy")
  // a parked result always has a result ahead of it in the output register
  `GBS_ASSERT_IMP(a_hold_out, hold_vld_q, m_vld_q && busy_q, "hold without output")
  // fill count never passes the store depth
  `GBS_ASSERT_ALW(a_count_range, count_q <= gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT), "kept count overflow")

endmodule

`default_nettype wire
